FILE: hdl/stt_pkg.sv
// Shared types, codes and character tables for the source text tokenizer.
// Used by stt_step, source_text_tokenizer and the simulation checker and test; depends on nothing else.
package stt_pkg;

  localparam int unsigned OFFSET_BITS = 20;
  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned KW_COUNT    = 27;

  // Record categories.
  localparam logic [3:0] CAT_KEYWORD = 4'd0;
  localparam logic [3:0] CAT_IDENT   = 4'd1;
  localparam logic [3:0] CAT_BOOL    = 4'd2;
  localparam logic [3:0] CAT_INT     = 4'd3;
  localparam logic [3:0] CAT_FLOAT   = 4'd4;
  localparam logic [3:0] CAT_STRING  = 4'd5;
  localparam logic [3:0] CAT_OPER    = 4'd6;
  localparam logic [3:0] CAT_PUNCT   = 4'd7;
  localparam logic [3:0] CAT_ERROR   = 4'd8;
  localparam logic [3:0] CAT_END     = 4'd9;

  // Scanner states.
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_WORD       = 4'd1;
  localparam logic [3:0] ST_INT        = 4'd2;
  localparam logic [3:0] ST_INT_DOT    = 4'd3;
  localparam logic [3:0] ST_FLOAT      = 4'd4;
  localparam logic [3:0] ST_OPER       = 4'd5;
  localparam logic [3:0] ST_STRING     = 4'd6;
  localparam logic [3:0] ST_LINE       = 4'd7;
  localparam logic [3:0] ST_BLOCK      = 4'd8;
  localparam logic [3:0] ST_BLOCK_STAR = 4'd9;
  localparam logic [3:0] ST_HALTED     = 4'd10;

  localparam logic [4:0] PUNCT_DOT_IDX = 5'd1;

  // Characters with a special role.
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Words packed little endian, first character in the low byte.
  localparam logic [63:0] WORD_FALSE = 64'h65736c6166;
  localparam logic [63:0] WORD_TRUE  = 64'h65757274;
  localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
    64'h38746e6975, 64'h3631746e6975, 64'h3233746e6975, 64'h3436746e6975,
    64'h38746e69, 64'h3631746e69, 64'h3233746e69, 64'h3436746e69,
    64'h3874616f6c66, 64'h363174616f6c66, 64'h323374616f6c66, 64'h343674616f6c66,
    64'h6c6f6f62, 64'h676e69727473, 64'h727470, 64'h666572,
    64'h7361, 64'h64696f76, 64'h636974617473, 64'h74736e6f63,
    64'h6669, 64'h65736c65, 64'h726f66, 64'h656c696877, 64'h6e7275746572,
    64'h6b61657262, 64'h65756e69746e6f63
  };

  typedef struct packed {
    logic [3:0]             scan;
    logic [OFFSET_BITS-1:0] tstart;
    logic [OFFSET_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] run;
    logic [63:0]            word;
    logic                   too_long;
    logic [7:0]             held;
    logic [OFFSET_BITS-1:0] dot;
  } stt_state_t;

  typedef struct packed {
    logic [3:0]             cat;
    logic [OFFSET_BITS-1:0] off;
    logic [LENGTH_BITS-1:0] len;
    logic [4:0]             idx;
    logic                   last;
  } stt_rec_t;

  function automatic stt_rec_t mk_rec(logic [3:0] cat, logic [OFFSET_BITS-1:0] off,
                                      logic [LENGTH_BITS-1:0] len, logic [4:0] idx);
    stt_rec_t r;
    r.cat  = cat;
    r.off  = off;
    r.len  = len;
    r.idx  = idx;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Single-byte operator: {hit, index}.
  function automatic logic [5:0] oper_single(logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h3D:   r = {1'b1, 5'd0};
      8'h21:   r = {1'b1, 5'd1};
      8'h2B:   r = {1'b1, 5'd2};
      8'h2D:   r = {1'b1, 5'd3};
      8'h2A:   r = {1'b1, 5'd4};
      8'h2F:   r = {1'b1, 5'd5};
      8'h25:   r = {1'b1, 5'd6};
      8'h3C:   r = {1'b1, 5'd14};
      8'h3E:   r = {1'b1, 5'd16};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // Operator followed by an equals sign.
  function automatic logic [4:0] oper_with_eq(logic [7:0] c);
    logic [4:0] r;
    case (c)
      8'h3D:   r = 5'd12;
      8'h21:   r = 5'd13;
      8'h2B:   r = 5'd7;
      8'h2D:   r = 5'd8;
      8'h2A:   r = 5'd9;
      8'h2F:   r = 5'd10;
      8'h25:   r = 5'd11;
      8'h3C:   r = 5'd15;
      default: r = 5'd17;
    endcase
    return r;
  endfunction

  // Punctuator: {hit, index}.
  function automatic logic [5:0] punct_index(logic [7:0] c);
    logic [5:0] r;
    case (c)
      8'h3B:   r = {1'b1, 5'd0};
      8'h2E:   r = {1'b1, 5'd1};
      8'h2C:   r = {1'b1, 5'd2};
      8'h28:   r = {1'b1, 5'd3};
      8'h29:   r = {1'b1, 5'd4};
      8'h7B:   r = {1'b1, 5'd5};
      8'h7D:   r = {1'b1, 5'd6};
      8'h5B:   r = {1'b1, 5'd7};
      8'h5D:   r = {1'b1, 5'd8};
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  // Keyword lookup over the fixed list: {hit, index}, compared in parallel.
  function automatic logic [5:0] kw_lookup(logic [63:0] w);
    logic [5:0] r;
    r = 6'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (w == KW_WORDS[k]) r = {1'b1, 5'(k)};
    end
    return r;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_add(logic [LENGTH_BITS-1:0] v,
                                                     logic [1:0] inc);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + {{(LENGTH_BITS-1){1'b0}}, inc};
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] off_inc(logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hdl/stt_step.sv
// Next-state and record logic of the tokenizer for one input item.
// Purely combinational; depends on stt_pkg.
module stt_step (
  input  stt_pkg::stt_state_t st_i,
  input  logic [7:0]          text_byte_i,
  input  logic                end_marker_i,
  output stt_pkg::stt_state_t st_o,
  output stt_pkg::stt_rec_t   rec0_o,
  output stt_pkg::stt_rec_t   rec1_o,
  output stt_pkg::stt_rec_t   rec2_o,
  output logic [1:0]          rec_n_o
);
  import stt_pkg::*;

  logic [7:0]             c;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [5:0]             kw, op_c, op_h, pu_c;
  stt_rec_t               word_rec, int_rec, fl0, fl1, pre0, pre1, srec;
  logic [1:0]             fl_n, pre_n;
  logic                   do_start, s_v;
  stt_state_t             mid, nx;

  assign c       = text_byte_i;
  assign pos_inc = off_inc(st_i.pos);
  assign kw      = kw_lookup(st_i.word);
  assign op_c    = oper_single(c);
  assign op_h    = oper_single(st_i.held);
  assign pu_c    = punct_index(c);

  // Records that close the pending token.
  always_comb begin
    if (!st_i.too_long && (st_i.word == WORD_FALSE || st_i.word == WORD_TRUE)) begin
      word_rec = mk_rec(CAT_BOOL, st_i.tstart, st_i.run, 5'd0);
    end else if (!st_i.too_long && kw[5]) begin
      word_rec = mk_rec(CAT_KEYWORD, st_i.tstart, st_i.run, kw[4:0]);
    end else begin
      word_rec = mk_rec(CAT_IDENT, st_i.tstart, st_i.run, 5'd0);
    end
    int_rec = mk_rec(CAT_INT, st_i.tstart, st_i.run, 5'd0);
    fl0  = word_rec;
    fl1  = mk_rec(CAT_PUNCT, st_i.dot, LENGTH_BITS'(1), PUNCT_DOT_IDX);
    fl_n = 2'd0;
    case (st_i.scan)
      ST_WORD: fl_n = 2'd1;
      ST_INT: begin
        fl0  = int_rec;
        fl_n = 2'd1;
      end
      ST_INT_DOT: begin
        fl0  = int_rec;
        fl_n = 2'd2;
      end
      ST_FLOAT: begin
        fl0  = mk_rec(CAT_FLOAT, st_i.tstart, st_i.run, 5'd0);
        fl_n = 2'd1;
      end
      ST_OPER: begin
        fl0  = mk_rec(CAT_OPER, st_i.tstart, LENGTH_BITS'(1), op_h[4:0]);
        fl_n = 2'd1;
      end
      ST_STRING: begin
        fl0  = mk_rec(CAT_STRING, st_i.tstart, st_i.run, 5'd0);
        fl_n = 2'd1;
      end
      default: fl_n = 2'd0;
    endcase
  end

  // Continue the pending token, or close it and hand the byte to the start logic.
  always_comb begin
    mid      = st_i;
    mid.pos  = pos_inc;
    pre0     = fl0;
    pre1     = fl1;
    pre_n    = 2'd0;
    do_start = 1'b0;
    case (st_i.scan)
      ST_IDLE: do_start = 1'b1;
      ST_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (st_i.run < LENGTH_BITS'(8)) begin
            mid.word[8*st_i.run[2:0] +: 8] = c;
          end else begin
            mid.too_long = 1'b1;
          end
          mid.run = len_add(st_i.run, 2'd1);
        end else begin
          pre_n    = 2'd1;
          do_start = 1'b1;
        end
      end
      ST_INT: begin
        if (is_digit(c)) begin
          mid.run = len_add(st_i.run, 2'd1);
        end else if (c == CH_DOT) begin
          mid.scan = ST_INT_DOT;
          mid.dot  = st_i.pos;
        end else begin
          pre_n    = 2'd1;
          do_start = 1'b1;
        end
      end
      ST_INT_DOT: begin
        if (is_digit(c)) begin
          mid.scan = ST_FLOAT;
          mid.run  = len_add(st_i.run, 2'd2);
        end else begin
          pre_n    = 2'd2;
          do_start = 1'b1;
        end
      end
      ST_FLOAT: begin
        if (is_digit(c)) begin
          mid.run = len_add(st_i.run, 2'd1);
        end else begin
          pre_n    = 2'd1;
          do_start = 1'b1;
        end
      end
      ST_OPER: begin
        if (st_i.held == CH_SLASH && c == CH_SLASH) begin
          mid.scan = ST_LINE;
        end else if (st_i.held == CH_SLASH && c == CH_STAR) begin
          mid.scan = ST_BLOCK;
        end else if (c == CH_EQ) begin
          pre0     = mk_rec(CAT_OPER, st_i.tstart, LENGTH_BITS'(2), oper_with_eq(st_i.held));
          pre_n    = 2'd1;
          mid.scan = ST_IDLE;
        end else begin
          pre_n    = 2'd1;
          do_start = 1'b1;
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          pre_n    = 2'd1;
          mid.scan = ST_IDLE;
        end else begin
          mid.run = len_add(st_i.run, 2'd1);
        end
      end
      ST_LINE: begin
        if (c == CH_NL) mid.scan = ST_IDLE;
      end
      ST_BLOCK: begin
        if (c == CH_STAR) mid.scan = ST_BLOCK_STAR;
      end
      ST_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          mid.scan = ST_IDLE;
        end else if (c != CH_STAR) begin
          mid.scan = ST_BLOCK;
        end
      end
      default: mid = st_i;
    endcase
    if (st_i.scan == ST_HALTED) mid.pos = pos_inc;
    // The end marker flushes whatever token is pending.
    if (end_marker_i) begin
      pre0  = fl0;
      pre1  = fl1;
      pre_n = fl_n;
    end
  end

  // Start of a new token from the current byte; end marker overrides everything.
  always_comb begin
    nx   = mid;
    s_v  = 1'b0;
    srec = mk_rec(CAT_ERROR, st_i.pos, LENGTH_BITS'(1), 5'd0);
    if (end_marker_i) begin
      nx    = '0;
      s_v   = 1'b1;
      srec  = mk_rec(CAT_END, st_i.pos, '0, 5'd0);
    end else if (do_start) begin
      nx.scan = ST_IDLE;
      if (!is_space(c)) begin
        nx.tstart = st_i.pos;
        nx.run    = LENGTH_BITS'(1);
        if (is_alpha(c)) begin
          nx.scan     = ST_WORD;
          nx.word     = {56'd0, c};
          nx.too_long = 1'b0;
        end else if (is_digit(c)) begin
          nx.scan = ST_INT;
        end else if (op_c[5]) begin
          nx.scan = ST_OPER;
          nx.held = c;
        end else if (pu_c[5]) begin
          s_v  = 1'b1;
          srec = mk_rec(CAT_PUNCT, st_i.pos, LENGTH_BITS'(1), pu_c[4:0]);
        end else if (c == CH_QUOTE) begin
          nx.scan   = ST_STRING;
          nx.tstart = pos_inc;
          nx.run    = '0;
        end else begin
          s_v     = 1'b1;
          nx.scan = ST_HALTED;
        end
      end
    end
  end

  // Pack closing records first, then the start record; flag the final one.
  always_comb begin
    rec0_o  = (pre_n != 2'd0) ? pre0 : srec;
    rec1_o  = (pre_n > 2'd1) ? pre1 : srec;
    rec2_o  = srec;
    rec_n_o = pre_n + {1'b0, s_v};
    case (rec_n_o)
      2'd1:    rec0_o.last = 1'b1;
      2'd2:    rec1_o.last = 1'b1;
      2'd3:    rec2_o.last = 1'b1;
      default: rec0_o.last = 1'b0;
    endcase
  end

  assign st_o = nx;

endmodule

FILE: hdl/source_text_tokenizer.sv
// Source text tokenizer: one byte per item in, token records out.
// Records are written into a registered output queue and leave it in order.
// Throughput: one item per cycle while the queue holds at most one record; an item
// makes up to three records, drained one per cycle from a four-entry output queue.
// Reset: rst_ni clears scanner state, offsets and the queue asynchronously.
// Depends on stt_pkg and stt_step.
module source_text_tokenizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_marker_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [3:0]                      category_o,
  output logic [stt_pkg::OFFSET_BITS-1:0] start_offset_o,
  output logic [stt_pkg::LENGTH_BITS-1:0] token_length_o,
  output logic [4:0]                      symbol_index_o,
  output logic                            last_of_run_o
);
  import stt_pkg::*;

  stt_state_t st_q, st_d;
  stt_rec_t   rec0, rec1, rec2, head;
  logic [1:0] rec_n, wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q;
  logic       acc, pop;
  logic [1:0] push_n;
  stt_rec_t   fifo_q [4];

  stt_step u_step (
    .st_i         (st_q),
    .text_byte_i  (text_byte_i),
    .end_marker_i (end_marker_i),
    .st_o         (st_d),
    .rec0_o       (rec0),
    .rec1_o       (rec1),
    .rec2_o       (rec2),
    .rec_n_o      (rec_n)
  );

  assign in_ready_o  = (cnt_q <= 3'd1);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = acc ? rec_n : 2'd0;

  // Scanner state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (acc) begin
      st_q <= st_d;
    end
  end

  // Output queue payload.
  always_ff @(posedge clk_i) begin
    if (push_n > 2'd0) fifo_q[wr_ptr_q] <= rec0;
    if (push_n > 2'd1) fifo_q[wr_ptr_q + 2'd1] <= rec1;
    if (push_n > 2'd2) fifo_q[wr_ptr_q + 2'd2] <= rec2;
  end

  // Output queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
    end
  end

  assign head           = fifo_q[rd_ptr_q];
  assign category_o     = head.cat;
  assign start_offset_o = head.off;
  assign token_length_o = head.len;
  assign symbol_index_o = head.idx;
  assign last_of_run_o  = head.last;

`ifndef SYNTHESIS
  // The queue never holds more than its four entries.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("output queue overflow");

  // An end marker always returns the scanner to idle.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && end_marker_i |=> st_q.scan == ST_IDLE) else $error("end marker did not reset");

  // After an error, bytes produce no records until the end marker.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !end_marker_i && st_q.scan == ST_HALTED |-> rec_n == 2'd0)
    else $error("record after error");
`endif

endmodule

FILE: sim/source_text_tokenizer_checker.sv
// Checker for the source text tokenizer: watches both channels, predicts the
// token records of every accepted item and compares them. Depends on stt_pkg.
module source_text_tokenizer_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_marker_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [3:0]                      category_i,
  input  logic [stt_pkg::OFFSET_BITS-1:0] start_offset_i,
  input  logic [stt_pkg::LENGTH_BITS-1:0] token_length_i,
  input  logic [4:0]                      symbol_index_i,
  input  logic                            last_of_run_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  import stt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_LIMIT = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_LIMIT = '1;

  // Scanner model state.
  logic [3:0]             scan;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [OFFSET_BITS-1:0] byte_pos;
  logic [LENGTH_BITS-1:0] tok_len;
  logic [63:0]            word_bytes;
  logic                   word_long;
  logic [7:0]             held_op;
  logic [OFFSET_BITS-1:0] dot_pos;

  stt_rec_t token_q[$];
  int       made;

  assign pending_o = token_q.size();

  function automatic logic letter(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic blank(logic [7:0] c);
    return c == 8'h20 || (c inside {[8'h09:8'h0D]});
  endfunction

  // Operator index of a lone byte, 31 when the byte is no operator.
  function automatic logic [4:0] lone_op(logic [7:0] c);
    case (c)
      "=": return 5'd0;
      "!": return 5'd1;
      "+": return 5'd2;
      "-": return 5'd3;
      "*": return 5'd4;
      "/": return 5'd5;
      "%": return 5'd6;
      "<": return 5'd14;
      ">": return 5'd16;
      default: return 5'd31;
    endcase
  endfunction

  function automatic logic [4:0] eq_op(logic [7:0] c);
    case (c)
      "=": return 5'd12;
      "!": return 5'd13;
      "+": return 5'd7;
      "-": return 5'd8;
      "*": return 5'd9;
      "/": return 5'd10;
      "%": return 5'd11;
      "<": return 5'd15;
      default: return 5'd17;
    endcase
  endfunction

  function automatic logic [4:0] punct_of(logic [7:0] c);
    case (c)
      ";": return 5'd0;
      ".": return 5'd1;
      ",": return 5'd2;
      "(": return 5'd3;
      ")": return 5'd4;
      "{": return 5'd5;
      "}": return 5'd6;
      "[": return 5'd7;
      "]": return 5'd8;
      default: return 5'd31;
    endcase
  endfunction

  task automatic push_token(logic [3:0] cat, logic [OFFSET_BITS-1:0] off,
                            logic [LENGTH_BITS-1:0] len, logic [4:0] idx);
    stt_rec_t r;
    r.cat  = cat;
    r.off  = off;
    r.len  = len;
    r.idx  = idx;
    r.last = 1'b0;
    token_q = {token_q, r};
    made++;
  endtask

  // A closed word is a boolean, a keyword or an identifier.
  task automatic close_word();
    int hit;
    hit = -1;
    if (!word_long) begin
      if (word_bytes == WORD_FALSE || word_bytes == WORD_TRUE) begin
        push_token(CAT_BOOL, tok_start, tok_len, 5'd0);
        return;
      end
      for (int k = 0; k < KW_COUNT; k++) begin
        if (hit < 0 && word_bytes == KW_WORDS[k]) hit = k;
      end
    end
    if (hit >= 0) push_token(CAT_KEYWORD, tok_start, tok_len, 5'(hit));
    else push_token(CAT_IDENT, tok_start, tok_len, 5'd0);
  endtask

  // A byte seen from the idle state opens a token, or is skipped or rejected.
  task automatic open_token(logic [7:0] c, logic [OFFSET_BITS-1:0] p);
    scan = ST_IDLE;
    if (blank(c)) return;
    tok_start = p;
    tok_len   = LENGTH_BITS'(1);
    if (letter(c)) begin
      scan       = ST_WORD;
      word_bytes = {56'd0, c};
      word_long  = 1'b0;
    end else if (digit(c)) begin
      scan = ST_INT;
    end else if (lone_op(c) != 5'd31) begin
      scan    = ST_OPER;
      held_op = c;
    end else if (punct_of(c) != 5'd31) begin
      push_token(CAT_PUNCT, p, LENGTH_BITS'(1), punct_of(c));
    end else if (c == CH_QUOTE) begin
      scan      = ST_STRING;
      tok_start = (p == OFF_LIMIT) ? p : p + 1'b1;
      tok_len   = '0;
    end else begin
      push_token(CAT_ERROR, p, LENGTH_BITS'(1), 5'd0);
      scan = ST_HALTED;
    end
  endtask

  task automatic flush_pending();
    case (scan)
      ST_WORD:   close_word();
      ST_INT:    push_token(CAT_INT, tok_start, tok_len, 5'd0);
      ST_INT_DOT: begin
        push_token(CAT_INT, tok_start, tok_len, 5'd0);
        push_token(CAT_PUNCT, dot_pos, LENGTH_BITS'(1), PUNCT_DOT_IDX);
      end
      ST_FLOAT:  push_token(CAT_FLOAT, tok_start, tok_len, 5'd0);
      ST_OPER:   push_token(CAT_OPER, tok_start, LENGTH_BITS'(1), lone_op(held_op));
      ST_STRING: push_token(CAT_STRING, tok_start, tok_len, 5'd0);
      default: ;
    endcase
  endtask

  function automatic logic [LENGTH_BITS-1:0] grow(logic [LENGTH_BITS-1:0] v, int inc);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + (LENGTH_BITS+1)'(inc);
    return s[LENGTH_BITS] ? LEN_LIMIT : s[LENGTH_BITS-1:0];
  endfunction

  task automatic clear_scanner();
    scan       = ST_IDLE;
    tok_start  = '0;
    byte_pos   = '0;
    tok_len    = '0;
    word_bytes = '0;
    word_long  = 1'b0;
    held_op    = '0;
    dot_pos    = '0;
  endtask

  // Advance the scanner by one item and queue the records it closes.
  task automatic tokenize_item(logic [7:0] c, logic endm);
    logic [OFFSET_BITS-1:0] p;
    p    = byte_pos;
    made = 0;
    if (endm) begin
      flush_pending();
      push_token(CAT_END, byte_pos, '0, 5'd0);
      token_q[$].last = 1'b1;
      clear_scanner();
      return;
    end
    case (scan)
      ST_IDLE: open_token(c, p);
      ST_WORD: begin
        if (letter(c) || digit(c)) begin
          if (tok_len < LENGTH_BITS'(8)) word_bytes[8*tok_len +: 8] = c;
          else word_long = 1'b1;
          tok_len = grow(tok_len, 1);
        end else begin
          close_word();
          open_token(c, p);
        end
      end
      ST_INT: begin
        if (digit(c)) tok_len = grow(tok_len, 1);
        else if (c == CH_DOT) begin
          scan    = ST_INT_DOT;
          dot_pos = p;
        end else begin
          push_token(CAT_INT, tok_start, tok_len, 5'd0);
          open_token(c, p);
        end
      end
      ST_INT_DOT: begin
        if (digit(c)) begin
          scan    = ST_FLOAT;
          tok_len = grow(tok_len, 2);
        end else begin
          flush_pending();
          open_token(c, p);
        end
      end
      ST_FLOAT: begin
        if (digit(c)) tok_len = grow(tok_len, 1);
        else begin
          push_token(CAT_FLOAT, tok_start, tok_len, 5'd0);
          open_token(c, p);
        end
      end
      ST_OPER: begin
        if (held_op == CH_SLASH && c == CH_SLASH) scan = ST_LINE;
        else if (held_op == CH_SLASH && c == CH_STAR) scan = ST_BLOCK;
        else if (c == CH_EQ) begin
          push_token(CAT_OPER, tok_start, LENGTH_BITS'(2), eq_op(held_op));
          scan = ST_IDLE;
        end else begin
          flush_pending();
          open_token(c, p);
        end
      end
      ST_STRING: begin
        if (c == CH_QUOTE) begin
          push_token(CAT_STRING, tok_start, tok_len, 5'd0);
          scan = ST_IDLE;
        end else tok_len = grow(tok_len, 1);
      end
      ST_LINE:  if (c == CH_NL) scan = ST_IDLE;
      ST_BLOCK: if (c == CH_STAR) scan = ST_BLOCK_STAR;
      ST_BLOCK_STAR: begin
        if (c == CH_SLASH) scan = ST_IDLE;
        else if (c != CH_STAR) scan = ST_BLOCK;
      end
      default: ;
    endcase
    byte_pos = (p == OFF_LIMIT) ? p : p + 1'b1;
    if (made > 0) token_q[$].last = 1'b1;
  endtask

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    clear_scanner();
  end

  // Predict on each accepted item, compare each accepted record.
  always @(posedge clk_i) begin
    stt_rec_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) tokenize_item(text_byte_i, end_marker_i);
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $error("unexpected record: category %0d offset %0d", category_i, start_offset_i);
          fail_count_o++;
        end else begin
          want = token_q.pop_front();
          checked_o++;
          if (category_i !== want.cat) begin
            $error("category: expected %0d, got %0d", want.cat, category_i);
            fail_count_o++;
          end
          if (start_offset_i !== want.off) begin
            $error("start_offset: expected %0d, got %0d", want.off, start_offset_i);
            fail_count_o++;
          end
          if (token_length_i !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, token_length_i);
            fail_count_o++;
          end
          if (symbol_index_i !== want.idx) begin
            $error("symbol_index: expected %0d, got %0d", want.idx, symbol_index_i);
            fail_count_o++;
          end
          if (last_of_run_i !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/source_text_tokenizer_test.sv
// Top of the tokenizer testbench: clock, reset, source text stimulus and verdict.
// Depends on stt_pkg, source_text_tokenizer and source_text_tokenizer_checker.
module source_text_tokenizer_test;
  import stt_pkg::*;

  localparam int WATCH_LIMIT = 3000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             text_byte = 8'h20;
  logic                   end_marker = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [3:0]             category;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] token_length;
  logic [4:0]             symbol_index;
  logic                   last_of_run;
  int                     fail_count, pending, checked;
  int                     sent = 0;
  int                     quiet = 0;
  logic                   steady = 1'b0;

  string fragments[] = '{
    "continue", "false", "true", "uint64", "float32", "abcdefghij", "x9", "Zq7",
    "123", "4.56", "7.", "7.z", "\"hi there\"", "\"", "+=", "%=", "<", ">=", "!",
    "-", "*=", "/", "==", "//c x\n", "/* a*b **/", "/*x", ";", ",", "()", "{}",
    "[]", " ", "\t", "\n", "0.0"
  };

  always #2 clk_i = ~clk_i;

  source_text_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .text_byte_i   (text_byte),
    .end_marker_i  (end_marker),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .category_o    (category),
    .start_offset_o(start_offset),
    .token_length_o(token_length),
    .symbol_index_o(symbol_index),
    .last_of_run_o (last_of_run)
  );

  source_text_tokenizer_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .text_byte_i   (text_byte),
    .end_marker_i  (end_marker),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .category_i    (category),
    .start_offset_i(start_offset),
    .token_length_i(token_length),
    .symbol_index_i(symbol_index),
    .last_of_run_i (last_of_run),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // Watchdog on cycles with no item or record accepted.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCH_LIMIT) begin
      $display("source_text_tokenizer test failed");
      $finish;
    end
  end

  // Offer one item and hold it until it is taken; random idle cycles may come before it.
  task automatic send_item(logic [7:0] b, logic endm);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    end_marker <= endm;
    do @(posedge clk_i); while (!in_ready);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
  endtask

  initial begin
    int r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every token kind but booleans, int-dot cases, a block comment, errors.
    send_text("if x1 9.5 7.a\"s\"+=/*a**/<");
    send_item(8'($urandom), 1'b1);
    send_text("q");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b1);
    send_text("3.");
    send_item(8'h80, 1'b0);
    send_item(8'h7F, 1'b1);

    // Let every record drain before the random part.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    // Random text: mostly well-formed fragments, some noise and end markers.
    while (sent < 250) begin
      steady = (sent >= 130 && sent < 180);
      r = $urandom_range(99);
      if (r < 4) send_item(8'($urandom), 1'b1);
      else if (r < 9) send_item(8'($urandom_range(255)), 1'b0);
      else begin
        send_text(fragments[$urandom_range(fragments.size() - 1)]);
        if ($urandom_range(1)) send_item(8'h20, 1'b0);
      end
    end
    steady = 1'b0;
    send_item(8'h20, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items of source text, checked %0d token records.", sent, checked);
    if (fail_count == 0) $display("source_text_tokenizer test passed");
    else $display("source_text_tokenizer test failed");
    $finish;
  end

endmodule
